// ----- hdl/history_score_table_with_aging_macros.svh -----
// assertion helpers shared by the block
`ifndef HISTORY_SCORE_TABLE_WITH_AGING_MACROS_SVH
`define HISTORY_SCORE_TABLE_WITH_AGING_MACROS_SVH

// same-cycle implication
`define HSTA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hsta_pkg.sv -----
package hsta_pkg;

    localparam int SCORE_W      = 17;
    localparam int PIECE_OFFSET = 6;

    localparam logic [SCORE_W-1:0] SCORE_MAX    = '1;
    localparam logic [SCORE_W-1:0] THRESH_RESET = 17'd100000;

    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_AGE
    } t_state;

endpackage

// ----- hdl/history_score_table_with_aging.sv -----
// channel   | valid        | flow control   | word
// ----------+--------------+----------------+------------------------------------------
// input     | i_in_valid   | o_in_stall     | i_action, i_piece, i_to_square, i_depth
// result    | o_out_valid  | i_out_stall    | o_score, o_index_valid, o_aged
// config    | i_cfg_valid  | o_cfg_ready    | i_cfg_age_threshold
//
// update and query read the table, then an update modifies and writes back in one memory port pair
// clear and invalid words answer at once; clear then walks the table, zeroing each entry
// an update that ages walks the table once more, halving each entry, with the input stalled
// after reset the clearing walk zeroes the whole table before any word is taken
// result register decouples the sides; a word is taken when idle and the result slot is free or draining
`include "history_score_table_with_aging_macros.svh"

module history_score_table_with_aging #(
    parameter int PIECE_KINDS = 13,
    parameter int SQUARES     = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_action,
    input  logic signed [3:0]                i_piece,
    input  logic [5:0]                       i_to_square,
    input  logic [5:0]                       i_depth,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hsta_pkg::SCORE_W-1:0]     o_score,
    output logic                             o_index_valid,
    output logic                             o_aged,
    // threshold write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hsta_pkg::SCORE_W-1:0]     i_cfg_age_threshold
);

    localparam int DEPTH = PIECE_KINDS * SQUARES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int SW    = hsta_pkg::SCORE_W;

    // score storage, one read and one write per cycle
    logic [SW-1:0] mem [DEPTH];

    hsta_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_addr;
    logic             r_is_update;
    logic [5:0]       r_depth;
    logic [SW-1:0]    r_rdata;
    logic             r_out_valid, n_out_valid;
    logic [SW-1:0]    r_score, n_score;
    logic             r_index_valid, n_index_valid;
    logic             r_aged, n_aged;
    logic [SW-1:0]    r_age_threshold;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [SW-1:0]    mem_wdata;
    logic             out_load;

    logic             in_fire, out_fire;
    logic [4:0]       row;
    logic             idx_valid;
    logic [AW-1:0]    in_addr;
    logic             is_access, is_clear;
    logic [11:0]      depth_sq;
    logic [SW:0]      sum;
    logic [SW-1:0]    upd_val;
    logic             age_now;
    logic [PW-1:0]    ptr_m1;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_fire = r_out_valid && !i_out_stall;

    // row = piece + 6, five bits signed so -8..7 maps to -2..13
    assign row       = {i_piece[3], i_piece} + 5'(hsta_pkg::PIECE_OFFSET);
    assign idx_valid = !row[4] && (32'(row[3:0]) < PIECE_KINDS)
                       && (32'(i_to_square) < SQUARES);
    assign in_addr   = AW'(row[3:0]) * AW'(SQUARES) + AW'(i_to_square);

    // action decode
    always_comb begin
        is_access = 1'b0;
        is_clear  = 1'b0;
        unique case (i_action)
            hsta_pkg::ACT_UPDATE,
            hsta_pkg::ACT_QUERY: begin
                is_access = idx_valid;
            end
            hsta_pkg::ACT_CLEAR: begin
                is_clear = 1'b1;
            end
            default: begin
                is_access = 1'b0;
            end
        endcase
    end

    // update arithmetic on the word read last cycle, saturating at full scale
    assign depth_sq = 12'(r_depth) * 12'(r_depth);
    assign sum      = {1'b0, r_rdata} + (SW+1)'(depth_sq);
    assign upd_val  = sum[SW] ? hsta_pkg::SCORE_MAX : sum[SW-1:0];
    assign age_now  = r_is_update && (upd_val > r_age_threshold);
    assign ptr_m1   = r_ptr - PW'(1);

    // stall unless idle with the result slot free or draining
    assign o_in_stall  = (r_state != hsta_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsta_pkg::S_CLEAR: begin
                if (r_ptr == PW'(DEPTH - 1)) begin
                    n_state = hsta_pkg::S_IDLE;
                end
            end
            hsta_pkg::S_IDLE: begin
                if (in_fire && is_clear) begin
                    n_state = hsta_pkg::S_CLEAR;
                end else if (in_fire && is_access) begin
                    n_state = hsta_pkg::S_READ;
                end
            end
            hsta_pkg::S_READ: begin
                n_state = age_now ? hsta_pkg::S_AGE : hsta_pkg::S_IDLE;
            end
            hsta_pkg::S_AGE: begin
                if (r_ptr == PW'(DEPTH)) begin
                    n_state = hsta_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsta_pkg::S_CLEAR;
            end
        endcase
    end

    // memory controls, sweep pointer and result loading
    always_comb begin
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = r_addr;
        mem_raddr     = in_addr;
        mem_wdata     = upd_val;
        n_ptr         = r_ptr;
        out_load      = 1'b0;
        n_score       = '0;
        n_index_valid = 1'b0;
        n_aged        = 1'b0;
        unique case (r_state)
            hsta_pkg::S_CLEAR: begin
                // zero one entry a cycle
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = '0;
                n_ptr     = r_ptr + PW'(1);
            end
            hsta_pkg::S_IDLE: begin
                n_ptr = '0;
                if (in_fire) begin
                    mem_re   = is_access;
                    // clear, unused code or bad index answer zero right away
                    out_load = !is_access;
                end
            end
            hsta_pkg::S_READ: begin
                // entry is written unhalved, the aging sweep halves it with the rest
                mem_we        = r_is_update;
                out_load      = 1'b1;
                n_index_valid = 1'b1;
                n_aged        = age_now;
                if (!r_is_update) begin
                    n_score = r_rdata;
                end else if (age_now) begin
                    n_score = upd_val >> 1;
                end else begin
                    n_score = upd_val;
                end
                n_ptr = '0;
            end
            hsta_pkg::S_AGE: begin
                // read entry ptr, write back entry ptr-1 halved
                mem_re    = (r_ptr != PW'(DEPTH));
                mem_raddr = r_ptr[AW-1:0];
                mem_we    = (r_ptr != '0);
                mem_waddr = ptr_m1[AW-1:0];
                mem_wdata = r_rdata >> 1;
                n_ptr     = r_ptr + PW'(1);
            end
            default: begin
                n_ptr = '0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= hsta_pkg::S_CLEAR;
            r_ptr           <= '0;
            r_out_valid     <= 1'b0;
            r_age_threshold <= hsta_pkg::THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_age_threshold <= i_cfg_age_threshold;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_addr      <= in_addr;
            r_is_update <= (i_action == hsta_pkg::ACT_UPDATE);
            r_depth     <= i_depth;
        end
        if (out_load) begin
            r_score       <= n_score;
            r_index_valid <= n_index_valid;
            r_aged        <= n_aged;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_score       = r_score;
    assign o_index_valid = r_index_valid;
    assign o_aged        = r_aged;

    // checks
    `HSTA_ASSERT_NOW(a_read_slot_free, r_state == hsta_pkg::S_READ, !r_out_valid,
                     "result slot busy at read-modify-write")
    `HSTA_ASSERT_NEXT(a_aged_sweeps, (r_state == hsta_pkg::S_READ) && age_now,
                      r_state == hsta_pkg::S_AGE, "aging result without a halving sweep")
    `HSTA_ASSERT_NOW(a_aged_valid, o_out_valid && o_aged, o_index_valid,
                     "aged flag on a word with a bad index")
    `HSTA_ASSERT_NEXT(a_read_once, r_state == hsta_pkg::S_READ, r_state != hsta_pkg::S_READ,
                      "read-modify-write held over a second cycle")

endmodule
